FILE: src/flc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flc_pkg: shared types and constants of the line correlator
// Request codes, controller states and the command/status bundles between
// controller and datapath.
// ----------------------------------------------------------------------------
package flc_pkg;

	localparam int TAPS_DEF  = 16;
	localparam int FRAC_DEF  = 14;
	localparam int CFG_W     = 5;
	localparam int DATA_W    = 16;
	localparam int CIDX_W    = 4;
	localparam int PROD_W    = 2 * DATA_W;

	localparam logic REQ_COEF   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	localparam logic [CFG_W-1:0] TAP_COUNT_RESET = CFG_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_WRITE
	} flc_state_t;

	typedef struct packed {
		logic push;
		logic wr_coef;
		logic clear_acc;
		logic issue;
		logic load_out;
	} flc_cmd_t;

	typedef struct packed {
		logic fire;
		logic busy;
		logic out_free;
	} flc_sts_t;

endpackage
`default_nettype wire

FILE: src/flc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flc_ctrl: sequencing of the line correlator
// Holds the tap count register, accepts requests and steps the shared
// multiply-accumulate through the window one tap per cycle.
// ----------------------------------------------------------------------------
module flc_ctrl #(
	parameter int TAPS = flc_pkg::TAPS_DEF,
	parameter int IW   = (TAPS > 1) ? $clog2(TAPS) : 1
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     req_type,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [flc_pkg::CFG_W-1:0] cfg_data,
	input  wire flc_pkg::flc_sts_t        sts,
	output flc_pkg::flc_cmd_t             cmd,
	output logic [IW-1:0]                 idx,
	output logic [IW-1:0]                 taps_m1
);
	import flc_pkg::*;

	flc_state_t       state_q, state_d;
	logic [CFG_W-1:0] tap_count_q;
	logic [IW-1:0]    idx_q;
	logic [6:0]       n_m1_w;
	logic             accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tap_count_q <= cfg_data;
		end
	end

	// clamp to 1..TAPS
	always_comb begin
		if (tap_count_q == '0) begin
			n_m1_w = '0;
		end else if (32'(tap_count_q) > 32'(TAPS)) begin
			n_m1_w = 7'(TAPS - 1);
		end else begin
			n_m1_w = 7'(tap_count_q) - 7'd1;
		end
	end

	assign taps_m1 = n_m1_w[IW-1:0];
	assign accept  = in_valid && in_ready;
	assign idx     = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd           = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.push      = in_valid && (req_type == REQ_SAMPLE);
				cmd.wr_coef   = in_valid && (req_type == REQ_COEF);
				cmd.clear_acc = in_valid;
				if (in_valid && (req_type == REQ_SAMPLE) && sts.fire) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (idx_q == taps_m1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.busy) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_issue_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (idx_q <= taps_m1))
		else $error("tap index beyond window");

	a_fire_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == REQ_SAMPLE) && sts.fire) |=> (state_q == ST_RUN))
		else $error("full window did not start accumulation");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !in_ready)
		else $error("request accepted during accumulation");

endmodule
`default_nettype wire

FILE: src/flc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flc_datapath: storage and arithmetic of the line correlator
// Weight memory, sample delay line, fill counter, pipelined multiply-
// accumulate, rounding, saturation and the result register.
// ----------------------------------------------------------------------------
module flc_datapath #(
	parameter int TAPS      = flc_pkg::TAPS_DEF,
	parameter int FRAC_BITS = flc_pkg::FRAC_DEF,
	parameter int IW        = (TAPS > 1) ? $clog2(TAPS) : 1
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire flc_pkg::flc_cmd_t                cmd,
	input  wire logic [IW-1:0]                    idx,
	input  wire logic [IW-1:0]                    taps_m1,
	output flc_pkg::flc_sts_t                     sts,
	input  wire logic                             line_start,
	input  wire logic [flc_pkg::CIDX_W-1:0]       coef_index,
	input  wire logic signed [flc_pkg::DATA_W-1:0] coef_value,
	input  wire logic signed [flc_pkg::DATA_W-1:0] sample,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [flc_pkg::DATA_W-1:0]     result,
	output logic                                  saturated
);
	import flc_pkg::*;

	localparam int CW    = $clog2(TAPS + 1);
	localparam int ACC_W = PROD_W + IW + 1;

	logic signed [DATA_W-1:0] weight_mem [TAPS];
	logic signed [DATA_W-1:0] window_q [TAPS];
	logic [CW-1:0]            fill_q, fill_d;
	logic [6:0]               cidx_w;
	logic                     coef_ok;
	logic [IW-1:0]            sel;
	logic signed [DATA_W-1:0] weight_s1, sample_s1;
	logic signed [PROD_W-1:0] product_s2;
	logic                     v_s1, v_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rounded;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] result_q;
	logic                     saturated_q;
	logic signed [DATA_W-1:0] result_d;
	logic                     sat_d;

	assign cidx_w  = 7'(coef_index);
	assign coef_ok = 32'(cidx_w) < 32'(TAPS);

	always_ff @(posedge clk) begin
		if (cmd.wr_coef && coef_ok) begin
			weight_mem[cidx_w[IW-1:0]] <= coef_value;
		end
	end

	always_ff @(posedge clk) begin
		weight_s1 <= weight_mem[idx];
		sample_s1 <= window_q[sel];
	end

	// advance the delay line, newest at position zero
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			window_q[0] <= sample;
			for (int k = 1; k < TAPS; k++) begin
				window_q[k] <= window_q[k-1];
			end
		end
	end

	always_comb begin
		if (line_start) begin
			fill_d = CW'(1);
		end else if (32'(fill_q) < 32'(TAPS)) begin
			fill_d = fill_q + CW'(1);
		end else begin
			fill_d = fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.push) begin
			fill_q <= fill_d;
		end
	end

	assign sel = taps_m1 - idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			product_s2 <= weight_s1 * sample_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_acc) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(product_s2);
		end
	end

	// round half up, floor shift, clip
	always_comb begin
		rounded = (acc_q + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (rounded > ACC_W'(32767)) begin
			result_d = 16'sh7FFF;
			sat_d    = 1'b1;
		end else if (rounded < -ACC_W'(32768)) begin
			result_d = -16'sh8000;
			sat_d    = 1'b1;
		end else begin
			result_d = rounded[DATA_W-1:0];
			sat_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q    <= result_d;
			saturated_q <= sat_d;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign saturated = saturated_q;

	assign sts.fire     = {1'b0, fill_d} >= ({1'b0, CW'(taps_m1)} + (CW + 1)'(1));
	assign sts.busy     = v_s1 || v_s2;
	assign sts.out_free = !out_valid_q || out_ready;

	a_load_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= 32'(TAPS))
		else $error("fill count beyond window");

	a_idle_pipe_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(v_s1 || v_s2))
		else $error("result taken before accumulation ended");

endmodule
`default_nettype wire

FILE: src/fir_line_correlator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fir_line_correlator_unit: one-dimensional line correlator
// Correlates a padded sample line with a loaded table of Q2.14 weights.
// ----------------------------------------------------------------------------
// A weight write, and a sample that does not complete a window, leave the
// block idle and ready for the next request. A sample that completes a
// window of n taps is stepped through one shared multiply-accumulate, one
// tap per cycle, behind a registered weight memory read and a two-stage
// product and sum pipeline, then rounded; the result register frees the block
// at once unless the previous result is still waiting there.
module fir_line_correlator_unit #(
	parameter int TAPS      = flc_pkg::TAPS_DEF,
	parameter int FRAC_BITS = flc_pkg::FRAC_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [flc_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              req_type,
	input  wire logic                              line_start,
	input  wire logic [flc_pkg::CIDX_W-1:0]        coef_index,
	input  wire logic signed [flc_pkg::DATA_W-1:0] coef_value,
	input  wire logic signed [flc_pkg::DATA_W-1:0] sample,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [flc_pkg::DATA_W-1:0]      result,
	output logic                                   saturated
);
	import flc_pkg::*;

	localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1;

	flc_cmd_t      cmd;
	flc_sts_t      sts;
	logic [IW-1:0] idx;
	logic [IW-1:0] taps_m1;

	flc_ctrl #(
		.TAPS (TAPS),
		.IW   (IW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.sts       (sts),
		.cmd       (cmd),
		.idx       (idx),
		.taps_m1   (taps_m1)
	);

	flc_datapath #(
		.TAPS      (TAPS),
		.FRAC_BITS (FRAC_BITS),
		.IW        (IW)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.idx        (idx),
		.taps_m1    (taps_m1),
		.sts        (sts),
		.line_start (line_start),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result     (result),
		.saturated  (saturated)
	);

endmodule
`default_nettype wire
